/* hw/rtl/qrr_pkg.sv */
// Shared types, constants and helpers for the quadrature rotary reporter.
// No dependencies; every other file in hw/rtl refers to this package by scoped name.

package qrr_pkg;

   // Hold-off counter width; the loaded count saturates at its all-ones value.
   localparam int HOLD_WIDTH = 16;
   localparam int TICKS_WIDTH = 16;

   // Job queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register map.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_INVERT_DIRECTION = 2'd0;
   localparam logic [1:0] REG_INVERT_BUTTON    = 2'd1;
   localparam logic [1:0] REG_HOLD_OFF_TICKS   = 2'd2;
   localparam logic [1:0] REG_ENCODER_ID       = 2'd3;

   localparam logic [TICKS_WIDTH-1:0] HOLD_OFF_RESET = 16'd100;
   localparam logic [7:0]             ENCODER_ID_RESET = 8'd1;

   // Input item and report codes.
   localparam logic MODE_PIN_SAMPLE = 1'b0;
   localparam logic MODE_TICK       = 1'b1;
   localparam logic KIND_ROTATION   = 1'b0;
   localparam logic KIND_BUTTON     = 1'b1;
   localparam logic DIR_CW          = 1'b0;
   localparam logic DIR_CCW         = 1'b1;

   localparam logic [7:0] POS_MAX   = 8'hff;
   localparam logic [7:0] STEP_FOLD = 8'd127;

   typedef struct packed {
      logic mode;
      logic chan_a;
      logic chan_b;
      logic button_level;
   } req_type;

   typedef struct packed {
      logic       report_kind;
      logic       direction;
      logic [7:0] step_count;
      logic [7:0] position_now;
      logic       pressed;
      logic [7:0] report_id;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic                   invert_direction;
      logic                   invert_button;
      logic [TICKS_WIDTH-1:0] hold_off_ticks;
      logic [7:0]             encoder_id;
   } cfg_type;

   // One queued job: the reports caused by one input item.
   typedef struct packed {
      logic       rot_valid;
      logic       direction;
      logic [7:0] step_count;
      logic       btn_valid;
      logic       pressed;
      logic [7:0] position_now;
      logic [7:0] report_id;
   } job_type;

   // Hold-off load: zero acts as one, saturate at the counter's range.
   function automatic logic [HOLD_WIDTH-1:0] hold_load(input logic [TICKS_WIDTH-1:0] ticks);
      logic [32:0] ext;
      logic [32:0] lim;
      ext = 33'(ticks);
      lim = (33'd1 << HOLD_WIDTH) - 33'd1;
      if (ext == 33'd0) begin
         ext = 33'd1;
      end
      if (ext > lim) begin
         ext = lim;
      end
      return ext[HOLD_WIDTH-1:0];
   endfunction

endpackage

/* hw/rtl/qrr_front.sv */
// Front part: accepts pin samples and ticks, tracks decoder and hold-off state,
// and builds one job per item that causes reports. Depends on qrr_pkg.

module qrr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qrr_pkg::req_type req_data,
   input  qrr_pkg::cfg_type cfg,
   input  logic             queue_full,
   output logic             job_push,
   output qrr_pkg::job_type job_data
);

   logic                           dir_a_ff, dir_a_in;
   logic                           settled_ff, settled_in;
   logic [7:0]                     position_ff, position_in;
   logic [7:0]                     reported_ff, reported_in;
   logic                           btn_seen_ff, btn_seen_in;
   logic                           btn_rep_ff, btn_rep_in;
   logic                           hold_active_ff, hold_active_in;
   logic [qrr_pkg::HOLD_WIDTH-1:0] hold_count_ff, hold_count_in;

   logic       accept;
   logic       up;
   logic       rot_fire;
   logic       btn_fire;
   logic       cw;
   logic [7:0] diff;
   logic [7:0] steps;
   logic [1:0] phase;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign phase     = {req_data.chan_b, req_data.chan_a};

   always_comb begin
      dir_a_in       = dir_a_ff;
      settled_in     = settled_ff;
      position_in    = position_ff;
      btn_seen_in    = btn_seen_ff;
      hold_active_in = hold_active_ff;
      hold_count_in  = hold_count_ff;
      up             = dir_a_ff ^ cfg.invert_direction;

      // Apply the item.
      if (req_data.mode == qrr_pkg::MODE_PIN_SAMPLE) begin
         btn_seen_in = req_data.button_level;
         if (phase == 2'b00 || phase == 2'b11) begin
            if (phase == 2'b00 && settled_ff) begin
               position_in = up ? position_ff + 8'd1 : position_ff - 8'd1;
            end
            settled_in = (phase == 2'b11);
         end else begin
            dir_a_in = phase[0];
         end
      end else if (hold_active_ff) begin
         if (hold_count_ff <= qrr_pkg::HOLD_WIDTH'(1)) begin
            hold_count_in  = '0;
            hold_active_in = 1'b0;
         end else begin
            hold_count_in = hold_count_ff - qrr_pkg::HOLD_WIDTH'(1);
         end
      end

      // Judge reports on the updated state.
      rot_fire = (position_in != reported_ff) && !hold_active_in;
      btn_fire = (btn_seen_in != btn_rep_ff);

      cw = ((position_in > reported_ff) ||
            (reported_ff == qrr_pkg::POS_MAX && position_in == 8'd0)) &&
           !(reported_ff == 8'd0 && position_in == qrr_pkg::POS_MAX);
      diff  = cw ? position_in - reported_ff : reported_ff - position_in;
      steps = (diff > qrr_pkg::STEP_FOLD) ? 8'(9'd256 - {1'b0, diff}) : diff;

      reported_in = reported_ff;
      btn_rep_in  = btn_rep_ff;
      if (rot_fire) begin
         hold_active_in = 1'b1;
         hold_count_in  = qrr_pkg::hold_load(cfg.hold_off_ticks);
         reported_in    = position_in;
      end
      if (btn_fire) begin
         btn_rep_in = btn_seen_in;
      end

      job_data.rot_valid    = rot_fire;
      job_data.direction    = cw ? qrr_pkg::DIR_CW : qrr_pkg::DIR_CCW;
      job_data.step_count   = steps;
      job_data.btn_valid    = btn_fire;
      job_data.pressed      = btn_seen_in ^ cfg.invert_button;
      job_data.position_now = position_in;
      job_data.report_id    = cfg.encoder_id;
      job_push              = accept && (rot_fire || btn_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_a_ff       <= 1'b0;
         settled_ff     <= 1'b0;
         position_ff    <= '0;
         reported_ff    <= '0;
         btn_seen_ff    <= 1'b0;
         btn_rep_ff     <= 1'b0;
         hold_active_ff <= 1'b0;
         hold_count_ff  <= '0;
      end else if (accept) begin
         dir_a_ff       <= dir_a_in;
         settled_ff     <= settled_in;
         position_ff    <= position_in;
         reported_ff    <= reported_in;
         btn_seen_ff    <= btn_seen_in;
         btn_rep_ff     <= btn_rep_in;
         hold_active_ff <= hold_active_in;
         hold_count_ff  <= hold_count_in;
      end
   end

   a_hold_count_tracks_active: assert property (@(posedge clock) disable iff (reset)
      hold_active_ff == (hold_count_ff != '0))
      else $error("hold-off count and active flag disagree");

endmodule

/* hw/rtl/qrr_queue.sv */
// Short job queue between front and back, held in flip-flops.
// Depends on qrr_pkg for the job type and depth.

module qrr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  qrr_pkg::job_type push_data,
   input  logic             pop,
   output qrr_pkg::job_type head,
   output logic             empty,
   output logic             full
);

   qrr_pkg::job_type                entry_ff [qrr_pkg::QUEUE_DEPTH];
   logic [qrr_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [qrr_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [qrr_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   localparam logic [qrr_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      qrr_pkg::QUEUE_PTR_W'(qrr_pkg::QUEUE_DEPTH - 1);

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == qrr_pkg::QUEUE_CNT_W'(qrr_pkg::QUEUE_DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from an empty queue");

endmodule

/* hw/rtl/qrr_back.sv */
// Back part: takes one job at a time from the queue and sends its rotation
// report, then its button report, from registers. Depends on qrr_pkg.

module qrr_back (
   input  logic             clock,
   input  logic             reset,
   input  qrr_pkg::job_type head,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qrr_pkg::rsp_type rsp_data
);

   qrr_pkg::job_type job_ff;
   logic             rot_pend_ff, rot_pend_in;
   logic             btn_pend_ff, btn_pend_in;
   logic             sent;
   logic             free;

   assign rsp_valid = rot_pend_ff || btn_pend_ff;
   assign sent      = rsp_valid && !rsp_stall;
   assign free      = !rsp_valid || (sent && !(rot_pend_ff && btn_pend_ff));
   assign pop       = free && !empty;

   always_comb begin
      rot_pend_in = rot_pend_ff;
      btn_pend_in = btn_pend_ff;
      if (pop) begin
         rot_pend_in = head.rot_valid;
         btn_pend_in = head.btn_valid;
      end else if (sent) begin
         if (rot_pend_ff) begin
            rot_pend_in = 1'b0;
         end else begin
            btn_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_pend_ff <= 1'b0;
         btn_pend_ff <= 1'b0;
      end else begin
         rot_pend_ff <= rot_pend_in;
         btn_pend_ff <= btn_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head;
      end
   end

   always_comb begin
      rsp_data.position_now = job_ff.position_now;
      rsp_data.report_id    = job_ff.report_id;
      if (rot_pend_ff) begin
         rsp_data.report_kind = qrr_pkg::KIND_ROTATION;
         rsp_data.direction   = job_ff.direction;
         rsp_data.step_count  = job_ff.step_count;
         rsp_data.pressed     = 1'b0;
         rsp_data.last        = !btn_pend_ff;
      end else begin
         rsp_data.report_kind = qrr_pkg::KIND_BUTTON;
         rsp_data.direction   = 1'b0;
         rsp_data.step_count  = '0;
         rsp_data.pressed     = job_ff.pressed;
         rsp_data.last        = 1'b1;
      end
   end

   a_job_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head.rot_valid || head.btn_valid))
      else $error("queued job carries no report");

   a_button_then_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rot_pend_ff) |-> rsp_data.last)
      else $error("button report not marked last");

   a_rotation_then_button: assert property (@(posedge clock) disable iff (reset)
      (sent && rot_pend_ff && btn_pend_ff) |=>
         (rsp_valid && rsp_data.report_kind == qrr_pkg::KIND_BUTTON))
      else $error("button report lost after rotation report");

endmodule

/* hw/rtl/quadrature_rotary_reporter.sv */
// Quadrature rotary reporter: each accepted item is a pin sample or a timer tick and
// causes zero, one or two reports (a rotation report first, then a button report).
// An item is taken in every cycle in which the four-entry job queue has room, so
// req_stall rises only when reports back up. An item's job is held first in the job
// queue and then in the back end's registers; while rsp_stall is low the back end
// sends one report per cycle, so items causing at most one report are taken at one
// item per cycle, and the two reports of an item causing two are sent one after the other.
// Depends on qrr_pkg, qrr_front, qrr_queue and qrr_back.
//
// Structure:
//   qrr_front - decodes quadrature, moves the 8-bit position, runs the hold-off
//               counter and the button edge check, and builds one job per item
//               that needs a report.
//   qrr_queue - holds up to QUEUE_DEPTH jobs so each side can stall on its own.
//   qrr_back  - sends the reports of one job from registers, marking the final
//               one with last.
// Configuration (APB, pready always high, written at psel & penable & pwrite):
//   0x0 invert_direction, 0x4 invert_button, 0x8 hold_off_ticks, 0xC encoder_id.
// Write configuration only while the block is idle.

module quadrature_rotary_reporter (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  qrr_pkg::req_type                 req_data,
   // reports
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output qrr_pkg::rsp_type                 rsp_data,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [qrr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [qrr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [qrr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   qrr_pkg::cfg_type cfg_ff, cfg_in;
   qrr_pkg::job_type job_push_data;
   qrr_pkg::job_type job_head;
   logic             job_push;
   logic             job_pop;
   logic             queue_empty;
   logic             queue_full;
   logic             csr_write;
   logic [1:0]       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   // Register file: update the addressed register on a write transfer.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            qrr_pkg::REG_INVERT_DIRECTION: cfg_in.invert_direction = pwdata[0];
            qrr_pkg::REG_INVERT_BUTTON:    cfg_in.invert_button    = pwdata[0];
            qrr_pkg::REG_HOLD_OFF_TICKS:
               cfg_in.hold_off_ticks = pwdata[qrr_pkg::TICKS_WIDTH-1:0];
            qrr_pkg::REG_ENCODER_ID:       cfg_in.encoder_id       = pwdata[7:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_direction <= 1'b0;
         cfg_ff.invert_button    <= 1'b0;
         cfg_ff.hold_off_ticks   <= qrr_pkg::HOLD_OFF_RESET;
         cfg_ff.encoder_id       <= qrr_pkg::ENCODER_ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register.
   always_comb begin
      case (csr_index)
         qrr_pkg::REG_INVERT_DIRECTION:
            prdata = qrr_pkg::CSR_DATA_W'(cfg_ff.invert_direction);
         qrr_pkg::REG_INVERT_BUTTON:
            prdata = qrr_pkg::CSR_DATA_W'(cfg_ff.invert_button);
         qrr_pkg::REG_HOLD_OFF_TICKS:
            prdata = qrr_pkg::CSR_DATA_W'(cfg_ff.hold_off_ticks);
         qrr_pkg::REG_ENCODER_ID:
            prdata = qrr_pkg::CSR_DATA_W'(cfg_ff.encoder_id);
         default:
            prdata = '0;
      endcase
   end

   // Front: classify and apply items, build jobs.
   qrr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_data   (job_push_data)
   );

   // Queue: decouple the two sides.
   qrr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // Back: send each job's reports in order.
   qrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (job_head),
      .empty     (queue_empty),
      .pop       (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
